/* hdl/ecmt_pkg.sv */
// Shared types and constants of the cartridge mapper and competition timer.
package ecmt_pkg;

    localparam int SCORE_SECONDS_DEF = 5;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 8;
    localparam int SIZE_W = 23;
    localparam int LIN_W  = 22;
    localparam int STEP_W = $clog2(LIN_W + 1);
    localparam int CFG_W  = 23;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SIZE_W-1:0] BANK_SIZE_RESET = 23'h100000;

    localparam logic [ADDR_W-1:0] B0_ROM_LOW_MASK  = 24'h808000;
    localparam logic [ADDR_W-1:0] B1_ROM_LOW_MASK  = 24'h208000;
    localparam logic [ADDR_W-1:0] STATUS_ADDR_A    = 24'h106000;
    localparam logic [ADDR_W-1:0] STATUS_ADDR_B    = 24'hc00000;
    localparam logic [ADDR_W-1:0] SELECT_ADDR_A    = 24'h206000;
    localparam logic [ADDR_W-1:0] SELECT_ADDR_B    = 24'he00000;

    localparam logic [DATA_W-1:0] SEL_START        = 8'h09;
    localparam logic [DATA_W-1:0] SEL_B0_BANK2     = 8'h05;
    localparam logic [DATA_W-1:0] SEL_B0_BANK3     = 8'h03;
    localparam logic [DATA_W-1:0] SEL_B1_BANK2     = 8'h0c;
    localparam logic [DATA_W-1:0] SEL_B1_BANK3     = 8'h0a;
    localparam logic [DATA_W-1:0] STATUS_DONE_BIT  = 8'h02;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_MEM_READ  = 2'd1,
        REQ_REG_READ  = 2'd2,
        REQ_REG_WRITE = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOARD_KIND    = 3'd0,
        CFG_TIMER_SECONDS = 3'd1,
        CFG_BANK0_SIZE    = 3'd2,
        CFG_BANK1_SIZE    = 3'd3,
        CFG_BANK2_SIZE    = 3'd4,
        CFG_BANK3_SIZE    = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        BK_IDLE,
        BK_MIRROR
    } back_state_t;

    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic [1:0]        bank;
        logic [LIN_W-1:0]  lin;
        logic              timer_running;
        logic              score_running;
    } work_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              rom_access;
        logic [1:0]        rom_bank;
        logic [LIN_W-1:0]  rom_offset;
        logic              timer_running;
        logic              score_running;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* hdl/ecmt_front.sv */
// Front end: accepts requests, updates timer and register state, decodes the ROM mapping.
module ecmt_front #(
    parameter int SCORE_SECONDS = ecmt_pkg::SCORE_SECONDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [1:0]                  req_type,
    input  logic [ecmt_pkg::ADDR_W-1:0] bus_address,
    input  logic [ecmt_pkg::DATA_W-1:0] bus_data,
    input  logic                        board_kind,
    input  logic [15:0]                 timer_seconds,
    input  ecmt_pkg::q_status_t         q_status,
    output logic                        q_push,
    output ecmt_pkg::work_t             q_data
);
    import ecmt_pkg::*;

    localparam int SCORE_W = $clog2(SCORE_SECONDS + 1);

    logic [DATA_W-1:0]  status_reg, status_next;
    logic [DATA_W-1:0]  select_reg, select_next;
    logic               timer_on_reg, timer_on_next;
    logic               score_on_reg, score_on_next;
    logic [15:0]        timer_left_reg, timer_left_next;
    logic [SCORE_W-1:0] score_left_reg, score_left_next;
    logic [1:0]         bank;
    logic [LIN_W-1:0]   lin;
    logic               hit;

    assign q_push = push & ~q_status.full;

    always_comb
    begin
        status_next     = status_reg;
        select_next     = select_reg;
        timer_on_next   = timer_on_reg;
        score_on_next   = score_on_reg;
        timer_left_next = timer_left_reg;
        score_left_next = score_left_reg;
        bank            = 2'd0;
        lin             = '0;
        hit             = 1'b0;
        q_data.read_data = bus_data;
        unique case (req_t'(req_type))
            REQ_TICK:
            begin
                q_data.read_data = '0;
                if (score_on_reg && score_left_reg != '0)
                begin
                    score_left_next = score_left_reg - SCORE_W'(1);
                    if (score_left_next == '0)
                    begin
                        score_on_next = 1'b0;
                    end
                end
                if (timer_on_reg && timer_left_reg != '0)
                begin
                    timer_left_next = timer_left_reg - 16'd1;
                    if (timer_left_next == '0)
                    begin
                        timer_on_next   = 1'b0;
                        status_next     = status_reg | STATUS_DONE_BIT;
                        score_on_next   = 1'b1;
                        score_left_next = SCORE_W'(SCORE_SECONDS);
                    end
                end
            end
            REQ_MEM_READ:
            begin
                if (!board_kind)
                begin
                    if (select_reg == SEL_START)    bank = 2'd1;
                    if (select_reg == SEL_B0_BANK2) bank = 2'd2;
                    if (select_reg == SEL_B0_BANK3) bank = 2'd3;
                    if ((bus_address & B0_ROM_LOW_MASK) == B0_ROM_LOW_MASK) bank = 2'd0;
                    if (bus_address[15])
                    begin
                        hit = 1'b1;
                        lin = {bus_address[22:16], bus_address[14:0]};
                    end
                end
                else
                begin
                    if (select_reg == SEL_START)    bank = 2'd1;
                    if (select_reg == SEL_B1_BANK2) bank = 2'd2;
                    if (select_reg == SEL_B1_BANK3) bank = 2'd3;
                    if ((bus_address & B1_ROM_LOW_MASK) == B1_ROM_LOW_MASK) bank = 2'd0;
                    if (bus_address[22])
                    begin
                        hit = 1'b1;
                        lin = bus_address[21:0];
                    end
                    else if (bus_address[15])
                    begin
                        hit = 1'b1;
                        if (bank == 2'd2)
                        begin
                            lin = {1'b0, bus_address[20:0]};
                        end
                        else
                        begin
                            lin = {2'b00, bus_address[20:16], bus_address[14:0]};
                        end
                    end
                end
                if (!hit)
                begin
                    bank = 2'd0;
                end
            end
            REQ_REG_READ:
            begin
                if (bus_address == STATUS_ADDR_A || bus_address == STATUS_ADDR_B)
                begin
                    q_data.read_data = status_reg;
                end
            end
            REQ_REG_WRITE:
            begin
                if (bus_address == SELECT_ADDR_A || bus_address == SELECT_ADDR_B)
                begin
                    select_next = bus_data;
                    if (timer_seconds != '0 && bus_data == SEL_START)
                    begin
                        timer_on_next   = 1'b1;
                        timer_left_next = timer_seconds;
                    end
                end
            end
        endcase
        q_data.hit           = hit;
        q_data.bank          = bank;
        q_data.lin           = lin;
        q_data.timer_running = timer_on_next;
        q_data.score_running = score_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= '0;
            select_reg     <= '0;
            timer_on_reg   <= 1'b0;
            score_on_reg   <= 1'b0;
            timer_left_reg <= '0;
            score_left_reg <= '0;
        end
        else if (q_push)
        begin
            status_reg     <= status_next;
            select_reg     <= select_next;
            timer_on_reg   <= timer_on_next;
            score_on_reg   <= score_on_next;
            timer_left_reg <= timer_left_next;
            score_left_reg <= score_left_next;
        end
    end

endmodule

/* hdl/ecmt_queue.sv */
// Two-entry queue of decoded requests between the front end and the mirror unit.
module ecmt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ecmt_pkg::work_t     wr_data,
    input  logic                rd_en,
    output ecmt_pkg::work_t     rd_data,
    output ecmt_pkg::q_status_t status
);
    import ecmt_pkg::*;

    work_t      head_reg;
    work_t      tail_reg;
    logic [1:0] count_reg, count_next;

    assign rd_data      = head_reg;
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en && count_reg == 2'd2)
        begin
            head_reg <= tail_reg;
        end
        else if (wr_en && (count_reg == 2'd0 || (count_reg == 2'd1 && rd_en)))
        begin
            head_reg <= wr_data;
        end
        if (wr_en && count_reg == 2'd1 && !rd_en)
        begin
            tail_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/ecmt_back.sv */
// Back end: folds the linear ROM address into the bank size one bit per cycle.
module ecmt_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ecmt_pkg::q_status_t   q_status,
    input  ecmt_pkg::work_t       q_data,
    input  ecmt_pkg::size_t [3:0] bank_size,
    input  logic                  pop,
    output logic                  q_pop,
    output logic                  empty,
    output ecmt_pkg::result_t     result
);
    import ecmt_pkg::*;

    back_state_t       state_reg, state_next;
    work_t             work_reg, work_next;
    logic [LIN_W-1:0]  addr_reg, addr_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [LIN_W-1:0]  base_reg, base_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic [STEP_W-1:0] pos;
    logic [LIN_W-1:0]  bit_val;
    logic              size_zero;
    logic              done;
    logic              out_free;

    assign empty  = ~out_valid_reg;
    assign result = out_reg;

    assign pos       = step_reg - STEP_W'(1);
    assign bit_val   = LIN_W'(1) << pos;
    assign size_zero = (size_reg == '0);
    assign done      = ~work_reg.hit | size_zero | ({1'b0, addr_reg} < size_reg)
                       | (step_reg == '0);
    assign out_free  = ~out_valid_reg | pop;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~pop;
        q_pop          = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_data;
                    addr_next  = q_data.lin;
                    size_next  = bank_size[q_data.bank];
                    base_next  = '0;
                    step_next  = STEP_W'(LIN_W);
                    state_next = BK_MIRROR;
                end
            end
            BK_MIRROR:
            begin
                if (done)
                begin
                    if (out_free)
                    begin
                        out_next.read_data     = work_reg.read_data;
                        out_next.rom_access    = work_reg.hit;
                        out_next.rom_bank      = work_reg.bank;
                        out_next.rom_offset    = size_zero ? '0 : base_reg + addr_reg;
                        out_next.timer_running = work_reg.timer_running;
                        out_next.score_running = work_reg.score_running;
                        out_valid_next         = 1'b1;
                        state_next             = BK_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                    if (addr_reg[pos[$clog2(LIN_W)-1:0]])
                    begin
                        addr_next = addr_reg - bit_val;
                        if (size_reg > {1'b0, bit_val})
                        begin
                            size_next = size_reg - {1'b0, bit_val};
                            base_next = base_reg + bit_val;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        base_reg <= base_next;
        step_reg <= step_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/event_cart_mapper_and_timer.sv */
// Top level of the cartridge mapper and competition timer.
//
//  Channel   | Handshake        | Fields
//  ----------+------------------+---------------------------------------------
//  request   | push / full      | req_type, bus_address, bus_data
//  result    | pop / empty      | read_data, rom_access, rom_bank, rom_offset,
//            |                  | timer_running, score_running
//  config    | cfg_write        | cfg_index, cfg_data
//
// A request enters the two-entry queue at the edge it is accepted; timer and register
// state are updated at that same edge. The mirror unit then pops it when idle, folds its
// address top bit first until it lies below the bank size, and registers the result.
// Reset clears control, timer, register and config state, not data registers; bank sizes
// return to 1 MiB. A held result stalls the mirror unit, and a full queue raises full.
module event_cart_mapper_and_timer #(
    parameter int SCORE_SECONDS = ecmt_pkg::SCORE_SECONDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     req_type,
    input  logic [ecmt_pkg::ADDR_W-1:0]    bus_address,
    input  logic [ecmt_pkg::DATA_W-1:0]    bus_data,
    output logic                           empty,
    input  logic                           pop,
    output logic [ecmt_pkg::DATA_W-1:0]    read_data,
    output logic                           rom_access,
    output logic [1:0]                     rom_bank,
    output logic [ecmt_pkg::LIN_W-1:0]     rom_offset,
    output logic                           timer_running,
    output logic                           score_running,
    input  logic                           cfg_write,
    input  logic [ecmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ecmt_pkg::CFG_W-1:0]     cfg_data
);
    import ecmt_pkg::*;

    logic        board_kind_reg;
    logic [15:0] timer_seconds_reg;
    size_t [3:0] bank_size_reg;
    logic        q_push;
    logic        q_pop;
    work_t       q_wr_data;
    work_t       q_rd_data;
    q_status_t   q_status;
    result_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_kind_reg    <= 1'b0;
            timer_seconds_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                bank_size_reg[i] <= BANK_SIZE_RESET;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BOARD_KIND:    board_kind_reg    <= cfg_data[0];
                CFG_TIMER_SECONDS: timer_seconds_reg <= cfg_data[15:0];
                CFG_BANK0_SIZE:    bank_size_reg[0]  <= cfg_data[SIZE_W-1:0];
                CFG_BANK1_SIZE:    bank_size_reg[1]  <= cfg_data[SIZE_W-1:0];
                CFG_BANK2_SIZE:    bank_size_reg[2]  <= cfg_data[SIZE_W-1:0];
                CFG_BANK3_SIZE:    bank_size_reg[3]  <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full = q_status.full;

    ecmt_front #(
        .SCORE_SECONDS(SCORE_SECONDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .req_type     (req_type),
        .bus_address  (bus_address),
        .bus_data     (bus_data),
        .board_kind   (board_kind_reg),
        .timer_seconds(timer_seconds_reg),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_data       (q_wr_data)
    );

    ecmt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data(q_wr_data),
        .rd_en  (q_pop),
        .rd_data(q_rd_data),
        .status (q_status)
    );

    ecmt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .bank_size(bank_size_reg),
        .pop      (pop),
        .q_pop    (q_pop),
        .empty    (empty),
        .result   (result)
    );

    assign read_data     = result.read_data;
    assign rom_access    = result.rom_access;
    assign rom_bank      = result.rom_bank;
    assign rom_offset    = result.rom_offset;
    assign timer_running = result.timer_running;
    assign score_running = result.score_running;

endmodule

/* hdl/ecmt_checker.sv */
// Port-level checker for the cartridge mapper and competition timer, bound to the top level.
module ecmt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic [ecmt_pkg::DATA_W-1:0] read_data,
    input logic                       rom_access,
    input logic [1:0]                 rom_bank,
    input logic [ecmt_pkg::LIN_W-1:0] rom_offset,
    input logic                       timer_running,
    input logic                       score_running
);
    import ecmt_pkg::*;

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_no_rom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rom_access) |-> (rom_bank == 2'd0 && rom_offset == '0))
        else $error("bank or offset set on a request that does not reach ROM");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(read_data) && $stable(rom_offset)
                              && $stable(rom_bank) && $stable(rom_access)
                              && $stable(timer_running) && $stable(score_running)))
        else $error("waiting result changed or vanished");

endmodule

bind event_cart_mapper_and_timer ecmt_checker u_ecmt_checker (.*);
